### rtl/sbct_pkg.sv
// Shared types, widths, register indexes and helpers of the swept box collision test unit.
package sbct_pkg;

    // Coordinate width of the transaction fields; sizes are one bit narrower and unsigned.
    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int FRAC_BITS  = 9;
    localparam int Q_SHIFT    = 8;

    // Geometry in Q.8 with headroom for grown edges and their differences.
    localparam int GEO_BITS   = COORD_BITS + 12;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int SCALE_BITS = FRAC_BITS + SIZE_BITS;
    localparam int SPLIT_BITS = GEO_BITS / 2;
    localparam int LO_PP_BITS = SPLIT_BITS + 1 + DELTA_BITS;
    localparam int HI_PP_BITS = GEO_BITS - SPLIT_BITS + DELTA_BITS;
    localparam int PROD_BITS  = GEO_BITS + DELTA_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;

    localparam int CFG_INDEX_BITS = 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [SIZE_BITS-1:0]  dim_t;
    typedef logic        [FRAC_BITS-1:0]  frac_t;
    typedef logic signed [GEO_BITS-1:0]   geo_t;
    typedef logic signed [DELTA_BITS-1:0] delta_t;
    typedef logic        [SCALE_BITS-1:0] scaled_t;
    typedef logic signed [LO_PP_BITS-1:0] lo_pp_t;
    typedef logic signed [HI_PP_BITS-1:0] hi_pp_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic [CFG_INDEX_BITS-1:0]    cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_OFFSET_FRACTION = 1'd0;
    localparam cfg_index_t REG_GROW_FRACTION   = 1'd1;

    localparam frac_t OFFSET_FRACTION_RESET = 9'd64;
    localparam frac_t GROW_FRACTION_RESET   = 9'd128;

    // Per-item qualifiers that travel alongside the products.
    typedef struct packed {
        logic top_ok;
        logic bottom_ok;
        logic left_ok;
        logic right_ok;
        logic start_enclosed;
        logic day_neg;
        logic dax_neg;
    } edge_flags_t;

    function automatic geo_t coord_to_geo(coord_t c);
        return {{(GEO_BITS-COORD_BITS-Q_SHIFT){c[COORD_BITS-1]}}, c, {Q_SHIFT{1'b0}}};
    endfunction

    function automatic geo_t dim_to_geo(dim_t d);
        return {{(GEO_BITS-SIZE_BITS-Q_SHIFT){1'b0}}, d, {Q_SHIFT{1'b0}}};
    endfunction

    function automatic geo_t scaled_to_geo(scaled_t s);
        return {{(GEO_BITS-SCALE_BITS){1'b0}}, s};
    endfunction

    function automatic logic sum_neg(sum_t s);
        return s[SUM_BITS-1];
    endfunction

    function automatic logic sum_pos(sum_t s);
        return !s[SUM_BITS-1] && (|s);
    endfunction

endpackage

### rtl/sbct_if.sv
// Valid/ready channel interfaces for items and results of the swept box collision test unit.
interface sbct_item_if import sbct_pkg::*;
    ;
    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    dim_t   mover_width;
    dim_t   mover_height;
    coord_t obstacle_left;
    coord_t obstacle_top;
    dim_t   obstacle_width;
    dim_t   obstacle_height;

    modport source (
        output valid, start_x, start_y, end_x, end_y, mover_width, mover_height,
               obstacle_left, obstacle_top, obstacle_width, obstacle_height,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, end_x, end_y, mover_width, mover_height,
               obstacle_left, obstacle_top, obstacle_width, obstacle_height,
        output ready
    );
endinterface

interface sbct_result_if import sbct_pkg::*;
    ;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

### rtl/swept_box_collision_test_unit.sv
// Swept box collision test unit: six-stage pipeline reporting a path/rectangle hit per item.
// The item passes through six register stages; result.valid is the valid bit of stage 6.
// Throughput: one item transaction per cycle unless the result side stalls; each stage
// holds its contents while the stage after it is full and stalled, and empty stages fill up
// behind a stall. The rate is set by the pipeline registers; the widest step is a split
// 36x25 multiply. Reset (rst_n low, asynchronous) empties every stage and restores both fractions.
module swept_box_collision_test_unit import sbct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  cfg_index_t    cfg_index,
    input  frac_t         cfg_data,
    sbct_item_if.sink     item,
    sbct_result_if.source result
);

    // Product lanes: the two horizontal offsets scaled by dy, the two vertical
    // offsets scaled by dx. Every edge test is a signed sum of two of these.
    localparam int LANES   = 4;
    localparam int LANE_A1 = 0;  // (sx - left)  * dy
    localparam int LANE_A2 = 1;  // (sx - right) * dy
    localparam int LANE_B1 = 2;  // (top - sy)    * dx
    localparam int LANE_B2 = 3;  // (bottom - sy) * dx

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipeline is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    frac_t offset_fraction_reg, offset_fraction_next;
    frac_t grow_fraction_reg,   grow_fraction_next;

    always_comb
    begin
        offset_fraction_next = offset_fraction_reg;
        grow_fraction_next   = grow_fraction_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_FRACTION: offset_fraction_next = cfg_data;
                REG_GROW_FRACTION:   grow_fraction_next   = cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_fraction_reg <= OFFSET_FRACTION_RESET;
            grow_fraction_reg   <= GROW_FRACTION_RESET;
        end
        else
        begin
            offset_fraction_reg <= offset_fraction_next;
            grow_fraction_reg   <= grow_fraction_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the stage
    // after it loads, so bubbles are squeezed out and a stall repeats nothing.
    // ------------------------------------------------------------------
    logic [6:1] valid_reg, valid_next;
    logic [6:1] adv;

    assign adv[6] = !valid_reg[6] || result.ready;
    assign adv[5] = !valid_reg[5] || adv[6];
    assign adv[4] = !valid_reg[4] || adv[5];
    assign adv[3] = !valid_reg[3] || adv[4];
    assign adv[2] = !valid_reg[2] || adv[3];
    assign adv[1] = !valid_reg[1] || adv[2];

    assign item.ready = adv[1];

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[1]) valid_next[1] = item.valid;
        if (adv[2]) valid_next[2] = valid_reg[1];
        if (adv[3]) valid_next[3] = valid_reg[2];
        if (adv[4]) valid_next[4] = valid_reg[3];
        if (adv[5]) valid_next[5] = valid_reg[4];
        if (adv[6]) valid_next[6] = valid_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: scale the mover size by both fractions and form the path deltas
    // in whole coordinate units (the Q.8 factor of 256 does not change signs).
    // ------------------------------------------------------------------
    coord_t  s1_start_x_reg, s1_start_y_reg, s1_end_x_reg, s1_end_y_reg;
    coord_t  s1_obs_left_reg, s1_obs_top_reg;
    dim_t    s1_obs_width_reg, s1_obs_height_reg;
    delta_t  s1_dax_reg, s1_day_reg, s1_dax_next, s1_day_next;
    scaled_t s1_off_w_reg, s1_off_h_reg, s1_grow_w_reg, s1_grow_h_reg;
    scaled_t s1_off_w_next, s1_off_h_next, s1_grow_w_next, s1_grow_h_next;

    always_comb
    begin
        s1_off_w_next  = scaled_t'(item.mover_width)  * scaled_t'(offset_fraction_reg);
        s1_off_h_next  = scaled_t'(item.mover_height) * scaled_t'(offset_fraction_reg);
        s1_grow_w_next = scaled_t'(item.mover_width)  * scaled_t'(grow_fraction_reg);
        s1_grow_h_next = scaled_t'(item.mover_height) * scaled_t'(grow_fraction_reg);
        s1_dax_next    = delta_t'({item.end_x[COORD_BITS-1], item.end_x})
                       - delta_t'({item.start_x[COORD_BITS-1], item.start_x});
        s1_day_next    = delta_t'({item.end_y[COORD_BITS-1], item.end_y})
                       - delta_t'({item.start_y[COORD_BITS-1], item.start_y});
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_start_x_reg    <= item.start_x;
            s1_start_y_reg    <= item.start_y;
            s1_end_x_reg      <= item.end_x;
            s1_end_y_reg      <= item.end_y;
            s1_obs_left_reg   <= item.obstacle_left;
            s1_obs_top_reg    <= item.obstacle_top;
            s1_obs_width_reg  <= item.obstacle_width;
            s1_obs_height_reg <= item.obstacle_height;
            s1_dax_reg        <= s1_dax_next;
            s1_day_reg        <= s1_day_next;
            s1_off_w_reg      <= s1_off_w_next;
            s1_off_h_reg      <= s1_off_h_next;
            s1_grow_w_reg     <= s1_grow_w_next;
            s1_grow_h_reg     <= s1_grow_h_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: build the grown rectangle in Q.8. An edge of zero length can
    // never be crossed, so its emptiness is noted here.
    // ------------------------------------------------------------------
    geo_t   s2_sx_reg, s2_sy_reg, s2_ex_reg, s2_ey_reg;
    geo_t   s2_sx_next, s2_sy_next, s2_ex_next, s2_ey_next;
    geo_t   s2_left_reg, s2_top_reg, s2_right_reg, s2_bottom_reg;
    geo_t   s2_left_next, s2_top_next, s2_right_next, s2_bottom_next;
    delta_t s2_dax_reg, s2_day_reg;
    logic   s2_dbx_nz_reg, s2_dby_nz_reg, s2_dbx_nz_next, s2_dby_nz_next;

    always_comb
    begin
        s2_sx_next     = coord_to_geo(s1_start_x_reg);
        s2_sy_next     = coord_to_geo(s1_start_y_reg);
        s2_ex_next     = coord_to_geo(s1_end_x_reg);
        s2_ey_next     = coord_to_geo(s1_end_y_reg);
        s2_left_next   = coord_to_geo(s1_obs_left_reg) - scaled_to_geo(s1_off_w_reg);
        s2_top_next    = coord_to_geo(s1_obs_top_reg)  - scaled_to_geo(s1_off_h_reg);
        s2_right_next  = s2_left_next + dim_to_geo(s1_obs_width_reg)
                       + scaled_to_geo(s1_grow_w_reg);
        s2_bottom_next = s2_top_next + dim_to_geo(s1_obs_height_reg)
                       + scaled_to_geo(s1_grow_h_reg);
        s2_dbx_nz_next = (|s1_obs_width_reg)  || (|s1_grow_w_reg);
        s2_dby_nz_next = (|s1_obs_height_reg) || (|s1_grow_h_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_sx_reg     <= s2_sx_next;
            s2_sy_reg     <= s2_sy_next;
            s2_ex_reg     <= s2_ex_next;
            s2_ey_reg     <= s2_ey_next;
            s2_left_reg   <= s2_left_next;
            s2_top_reg    <= s2_top_next;
            s2_right_reg  <= s2_right_next;
            s2_bottom_reg <= s2_bottom_next;
            s2_dax_reg    <= s1_dax_reg;
            s2_day_reg    <= s1_day_reg;
            s2_dbx_nz_reg <= s2_dbx_nz_next;
            s2_dby_nz_reg <= s2_dby_nz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the path parameter test of every edge reduces to the path
    // straddling the edge's line (start on or past it, end strictly beyond).
    // The position along the edge needs products, so the offsets are formed.
    // ------------------------------------------------------------------
    geo_t        s3_diff_reg [LANES];
    geo_t        s3_diff_next [LANES];
    delta_t      s3_dax_reg, s3_day_reg;
    edge_flags_t s3_flags_reg, s3_flags_next;

    always_comb
    begin
        s3_diff_next[LANE_A1] = s2_sx_reg - s2_left_reg;
        s3_diff_next[LANE_A2] = s2_sx_reg - s2_right_reg;
        s3_diff_next[LANE_B1] = s2_top_reg - s2_sy_reg;
        s3_diff_next[LANE_B2] = s2_bottom_reg - s2_sy_reg;

        s3_flags_next.top_ok    = s2_dbx_nz_reg &&
            ((s2_sy_reg <= s2_top_reg && s2_ey_reg > s2_top_reg) ||
             (s2_sy_reg >= s2_top_reg && s2_ey_reg < s2_top_reg));
        s3_flags_next.bottom_ok = s2_dbx_nz_reg &&
            ((s2_sy_reg <= s2_bottom_reg && s2_ey_reg > s2_bottom_reg) ||
             (s2_sy_reg >= s2_bottom_reg && s2_ey_reg < s2_bottom_reg));
        s3_flags_next.left_ok   = s2_dby_nz_reg &&
            ((s2_sx_reg <= s2_left_reg && s2_ex_reg > s2_left_reg) ||
             (s2_sx_reg >= s2_left_reg && s2_ex_reg < s2_left_reg));
        s3_flags_next.right_ok  = s2_dby_nz_reg &&
            ((s2_sx_reg <= s2_right_reg && s2_ex_reg > s2_right_reg) ||
             (s2_sx_reg >= s2_right_reg && s2_ex_reg < s2_right_reg));
        // A start point on the boundary does not count as enclosed.
        s3_flags_next.start_enclosed = (s2_sx_reg > s2_left_reg) && (s2_sx_reg < s2_right_reg) &&
                                       (s2_sy_reg > s2_top_reg)  && (s2_sy_reg < s2_bottom_reg);
        s3_flags_next.day_neg   = s2_day_reg[DELTA_BITS-1];
        s3_flags_next.dax_neg   = s2_dax_reg[DELTA_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int k = 0; k < LANES; k++)
            begin
                s3_diff_reg[k] <= s3_diff_next[k];
            end
            s3_dax_reg   <= s2_dax_reg;
            s3_day_reg   <= s2_day_reg;
            s3_flags_reg <= s3_flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: each wide offset is split into an unsigned low half and a
    // signed high half, and each half is multiplied by the path delta.
    // ------------------------------------------------------------------
    logic signed [SPLIT_BITS:0]          lo_op [LANES];
    logic signed [GEO_BITS-SPLIT_BITS-1:0] hi_op [LANES];
    delta_t      mul_d [LANES];
    lo_pp_t      s4_lo_reg [LANES];
    lo_pp_t      s4_lo_next [LANES];
    hi_pp_t      s4_hi_reg [LANES];
    hi_pp_t      s4_hi_next [LANES];
    edge_flags_t s4_flags_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lo_op[k]      = signed'({1'b0, s3_diff_reg[k][SPLIT_BITS-1:0]});
            hi_op[k]      = s3_diff_reg[k][GEO_BITS-1:SPLIT_BITS];
            mul_d[k]      = (k == LANE_A1 || k == LANE_A2) ? s3_day_reg : s3_dax_reg;
            s4_lo_next[k] = lo_op[k] * mul_d[k];
            s4_hi_next[k] = hi_op[k] * mul_d[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int k = 0; k < LANES; k++)
            begin
                s4_lo_reg[k] <= s4_lo_next[k];
                s4_hi_reg[k] <= s4_hi_next[k];
            end
            s4_flags_reg <= s3_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: recombine the partial products into exact full products.
    // ------------------------------------------------------------------
    prod_t       s5_prod_reg [LANES];
    prod_t       s5_prod_next [LANES];
    edge_flags_t s5_flags_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            s5_prod_next[k] = (prod_t'(s4_hi_reg[k]) <<< SPLIT_BITS) + prod_t'(s4_lo_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int k = 0; k < LANES; k++)
            begin
                s5_prod_reg[k] <= s5_prod_next[k];
            end
            s5_flags_reg <= s4_flags_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: the crossing point along an edge lies within the edge when the
    // offset from one end and the offset from the other end, both scaled by
    // the path delta across the edge, have the right signs. The vertical edges
    // reuse the horizontal sums with the opposite sign.
    // ------------------------------------------------------------------
    sum_t n_top, m_top, n_bot, m_bot;
    logic hit_top, hit_bottom, hit_left, hit_right;
    logic hit_reg, hit_next;

    always_comb
    begin
        n_top = sum_t'(s5_prod_reg[LANE_A1]) + sum_t'(s5_prod_reg[LANE_B1]);
        m_top = sum_t'(s5_prod_reg[LANE_A2]) + sum_t'(s5_prod_reg[LANE_B1]);
        n_bot = sum_t'(s5_prod_reg[LANE_A1]) + sum_t'(s5_prod_reg[LANE_B2]);
        m_bot = sum_t'(s5_prod_reg[LANE_A2]) + sum_t'(s5_prod_reg[LANE_B2]);

        hit_top    = s5_flags_reg.top_ok &&
            (s5_flags_reg.day_neg ? (!sum_pos(n_top) && sum_pos(m_top))
                                  : (!sum_neg(n_top) && sum_neg(m_top)));
        hit_bottom = s5_flags_reg.bottom_ok &&
            (s5_flags_reg.day_neg ? (!sum_pos(n_bot) && sum_pos(m_bot))
                                  : (!sum_neg(n_bot) && sum_neg(m_bot)));
        hit_left   = s5_flags_reg.left_ok &&
            (s5_flags_reg.dax_neg ? (!sum_neg(n_top) && sum_neg(n_bot))
                                  : (!sum_pos(n_top) && sum_pos(n_bot)));
        hit_right  = s5_flags_reg.right_ok &&
            (s5_flags_reg.dax_neg ? (!sum_neg(m_top) && sum_neg(m_bot))
                                  : (!sum_pos(m_top) && sum_pos(m_bot)));

        hit_next = hit_top || hit_bottom || hit_left || hit_right ||
                   s5_flags_reg.start_enclosed;
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            hit_reg <= hit_next;
        end
    end

    assign result.valid = valid_reg[6];
    assign result.hit   = hit_reg;

endmodule
